FILE: src/ava_pkg.sv
// ----------------------------------------------------------------------------
// ava_pkg
// Shared types and constants of the accelerated value adjuster.
// ----------------------------------------------------------------------------
package ava_pkg;

   // key event codes
   localparam logic [1:0] KEY_NONE   = 2'd0;
   localparam logic [1:0] KEY_PRESS  = 2'd1;
   localparam logic [1:0] KEY_REPEAT = 2'd2;

   // csr register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VALUE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALUE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_STEP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_STEP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_ENABLE = 3'd4;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [15:0] MIN_VALUE_RESET    = 16'd0;
   localparam logic [15:0] MAX_VALUE_RESET    = 16'hFFFF;
   localparam logic [7:0]  BASE_STEP_RESET    = 8'd1;
   localparam logic [7:0]  TARGET_STEP_RESET  = 8'd10;
   localparam logic        ACCEL_ENABLE_RESET = 1'b1;

   // fixed behaviour constants
   localparam logic [7:0]  PRESS_INTERVAL = 8'd5;
   localparam logic [16:0] DIV10_RECIP    = 17'd52429;  // ceil(2^19 / 10)
   localparam int          DIV10_SHIFT    = 19;

   // default parameter values
   localparam int SLOWEST_INTERVAL_DEFAULT = 10;
   localparam int HOLD_PER_LEVEL_DEFAULT   = 4;

   typedef struct packed {
      logic [1:0]  key_event;
      logic        direction;
      logic [15:0] current_value;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [15:0] new_value;
      logic        overflow;
      logic [7:0]  repeat_interval;
   } rsp_type;

endpackage

FILE: src/accelerated_value_adjuster.sv
// ----------------------------------------------------------------------------
// accelerated_value_adjuster
// Steps an edited value up or down on key presses and repeat ticks, with
// clamping, overflow flag and hold acceleration of interval and step.
// ----------------------------------------------------------------------------
// a response enters the output register in the cycle after its request is accepted
// throughput: one transaction per cycle while requests are not stalled, set by the
//    update of the hold counter and active step, which feed the next transaction
// a new request is taken while the response register is empty or being drained
// reset: synchronous, active high; clears hold state and the response valid,
//    loads csr reset values
module accelerated_value_adjuster #(
   parameter int SLOWEST_INTERVAL = ava_pkg::SLOWEST_INTERVAL_DEFAULT,
   parameter int HOLD_PER_LEVEL   = ava_pkg::HOLD_PER_LEVEL_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ava_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ava_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [ava_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ava_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int HOLD_LIMIT = (SLOWEST_INTERVAL - 1) * HOLD_PER_LEVEL;
   // hold level by reciprocal multiply, exact for an 8-bit count
   localparam int LEVEL_SHIFT = 16;
   localparam logic [16:0] LEVEL_RECIP =
      17'(((1 << LEVEL_SHIFT) + HOLD_PER_LEVEL - 1) / HOLD_PER_LEVEL);

   // csr registers
   logic [15:0] min_value_ff, max_value_ff;
   logic [7:0]  base_step_ff, target_step_ff;
   logic        accel_enable_ff;

   // hold state
   logic [7:0]  hold_count_ff, hold_count_in;
   logic [7:0]  active_step_ff, active_step_in;
   logic        boundary_seen_ff, boundary_seen_in;
   logic [7:0]  interval_ff, interval_in;
   logic        overflow_ff, overflow_in;

   // response register
   logic              rsp_valid_ff;
   ava_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic req_accept;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // multiple-of-ten test by reciprocal multiply
   logic [15:0] cur_value;
   logic [32:0] recip_prod;
   logic [15:0] quot10;
   logic [15:0] quot10_x10;
   logic        is_mult10;

   assign cur_value  = req_data.current_value;
   assign recip_prod = {17'd0, cur_value} * {16'd0, ava_pkg::DIV10_RECIP};
   assign quot10     = 16'(recip_prod >> ava_pkg::DIV10_SHIFT);
   assign quot10_x10 = {quot10[12:0], 3'b000} + {quot10[14:0], 1'b0};
   assign is_mult10  = (quot10_x10 == cur_value);

   // event decode and hold update
   logic        do_press, do_tick, do_step;
   logic [7:0]  hold_inc;
   logic [24:0] level_prod;
   logic [7:0]  hold_level;
   logic [7:0]  step_used;

   always_comb begin
      do_press = (req_data.key_event == ava_pkg::KEY_PRESS) ||
                 ((req_data.key_event == ava_pkg::KEY_REPEAT) && !accel_enable_ff);
      do_tick  = (req_data.key_event == ava_pkg::KEY_REPEAT) && accel_enable_ff;
      do_step  = do_press || do_tick;

      hold_inc = hold_count_ff;
      if ((int'(hold_count_ff) <= HOLD_LIMIT) && (hold_count_ff != 8'hFF)) begin
         hold_inc = hold_count_ff + 8'd1;
      end
      level_prod = {17'd0, hold_inc} * {8'd0, LEVEL_RECIP};
      hold_level = 8'(level_prod >> LEVEL_SHIFT);

      hold_count_in    = 8'd0;
      active_step_in   = base_step_ff;
      boundary_seen_in = 1'b0;
      interval_in      = ava_pkg::PRESS_INTERVAL;

      if (do_tick) begin
         hold_count_in = hold_inc;
         interval_in   = 8'(SLOWEST_INTERVAL) - hold_level;
         if (int'(hold_inc) > HOLD_LIMIT) begin
            // long hold: grow the step once the value has sat on a multiple of ten
            if (boundary_seen_ff) begin
               active_step_in = (active_step_ff < target_step_ff) ?
                                active_step_ff + 8'd1 : active_step_ff;
            end
            boundary_seen_in = boundary_seen_ff || is_mult10;
         end
      end
      step_used = active_step_in;
   end

   // step and clamp
   logic [15:0] step16;
   logic [15:0] diff;
   logic        dec_room;
   logic [16:0] sum;
   logic        step_ovf;
   logic [15:0] stepped;
   logic [15:0] clamped;

   always_comb begin
      step16   = {8'd0, step_used};
      diff     = cur_value - step16;
      dec_room = (cur_value != 16'd0) && (cur_value >= step16);
      sum      = {1'b0, cur_value} + {1'b0, step16};
      if (!req_data.direction) begin
         step_ovf = !(dec_room && (diff >= min_value_ff));
         stepped  = (dec_room && (diff > min_value_ff)) ? diff : min_value_ff;
      end else begin
         step_ovf = (sum > {1'b0, max_value_ff});
         stepped  = step_ovf ? max_value_ff : sum[15:0];
      end
      clamped = stepped;
      // max wins when the range is inverted
      if (clamped < min_value_ff) begin
         clamped = min_value_ff;
      end
      if (clamped > max_value_ff) begin
         clamped = max_value_ff;
      end

      overflow_in = do_step ? step_ovf : overflow_ff;

      rsp_data_in.accepted        = do_step;
      rsp_data_in.new_value       = do_step ? clamped : cur_value;
      rsp_data_in.overflow        = overflow_in;
      rsp_data_in.repeat_interval = interval_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_value_ff    <= ava_pkg::MIN_VALUE_RESET;
         max_value_ff    <= ava_pkg::MAX_VALUE_RESET;
         base_step_ff    <= ava_pkg::BASE_STEP_RESET;
         target_step_ff  <= ava_pkg::TARGET_STEP_RESET;
         accel_enable_ff <= ava_pkg::ACCEL_ENABLE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ava_pkg::CSR_MIN_VALUE:    min_value_ff    <= csr_data[15:0];
            ava_pkg::CSR_MAX_VALUE:    max_value_ff    <= csr_data[15:0];
            ava_pkg::CSR_BASE_STEP:    base_step_ff    <= csr_data[7:0];
            ava_pkg::CSR_TARGET_STEP:  target_step_ff  <= csr_data[7:0];
            ava_pkg::CSR_ACCEL_ENABLE: accel_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff    <= 8'd0;
         active_step_ff   <= ava_pkg::BASE_STEP_RESET;
         boundary_seen_ff <= 1'b0;
         interval_ff      <= 8'd0;
         overflow_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_accept) begin
            hold_count_ff    <= hold_count_in;
            active_step_ff   <= active_step_in;
            boundary_seen_ff <= boundary_seen_in;
            interval_ff      <= interval_in;
            overflow_ff      <= overflow_in;
            rsp_valid_ff     <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // every accepted transaction shows up in the response register
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("response missing after accepted request");

   // anything but an accelerated repeat tick drops the hold state
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !(req_data.key_event == ava_pkg::KEY_REPEAT && accel_enable_ff))
      |=> (hold_count_ff == 8'd0 && !boundary_seen_ff &&
           interval_ff == ava_pkg::PRESS_INTERVAL))
      else $error("hold state not cleared");

   // the interval and overflow flag stored match the ones reported
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_data_ff.repeat_interval == interval_ff &&
                      rsp_data_ff.overflow == overflow_ff))
      else $error("response out of step with hold state");
`endif

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accelerated value adjuster. Key event
// transactions are queued by a stimulus sequence and sent by a clocked
// driver. Each accepted transaction is run through a local model of the
// hold counter, step growth and clamping. A clocked monitor compares every
// response field against the oldest predicted adjustment. Phases change the
// range and step registers and the amount of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
   import ava_pkg::*;

   localparam logic [1:0] KEY_RESERVED = 2'd3;
   localparam int HOLD_LIMIT = (SLOWEST_INTERVAL_DEFAULT - 1) * HOLD_PER_LEVEL_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 10;
   localparam int EVENTS_PER_PHASE = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MIN_VALUE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   req_type key_events_to_send[$];
   rsp_type awaited_adjustments[$];
   rsp_type oldest_adjustment;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int cycle_count = 0;

   // local copy of the registers
   int unsigned lo_limit, hi_limit, step_base, step_target, accel_on;
   // local copy of the hold state
   int unsigned hold_ticks, cur_step, seen_ten;
   logic [7:0] interval_now;
   logic limit_hit;

   accelerated_value_adjuster dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void release_hold();
      hold_ticks = 0;
      interval_now = PRESS_INTERVAL;
      seen_ten = 0;
      cur_step = step_base;
   endfunction

   // moves the value by the active step and clamps it, updating the held flag
   function automatic logic [15:0] stepped_value(int unsigned cur, logic up);
      int unsigned nv;
      if (!up) begin
         limit_hit = !(cur != 0 && cur >= cur_step && cur - cur_step >= lo_limit);
         nv = (cur != 0 && cur >= cur_step && cur - cur_step > lo_limit) ?
              cur - cur_step : lo_limit;
      end else begin
         limit_hit = (cur + cur_step > hi_limit);
         nv = (cur + cur_step <= hi_limit) ? cur + cur_step : hi_limit;
      end
      if (nv < lo_limit) nv = lo_limit;
      if (nv > hi_limit) nv = hi_limit;
      return nv[15:0];
   endfunction

   function automatic rsp_type next_adjustment(req_type ev);
      rsp_type res;
      int level;
      res.accepted = 1'b0;
      res.new_value = ev.current_value;
      if (ev.key_event == KEY_PRESS || (ev.key_event == KEY_REPEAT && accel_on == 0)) begin
         release_hold();
         res.new_value = stepped_value(ev.current_value, ev.direction);
         res.accepted = 1'b1;
      end else if (ev.key_event == KEY_REPEAT) begin
         if (hold_ticks <= HOLD_LIMIT && hold_ticks < 255) hold_ticks++;
         level = SLOWEST_INTERVAL_DEFAULT - int'(hold_ticks / HOLD_PER_LEVEL_DEFAULT);
         interval_now = level[7:0];
         if (hold_ticks > HOLD_LIMIT) begin
            // growth only starts on the tick after a multiple of ten was seen
            if (seen_ten != 0) begin
               if (cur_step < step_target) cur_step++;
            end else begin
               cur_step = step_base;
            end
            if (ev.current_value % 10 == 0) seen_ten = 1;
         end else begin
            seen_ten = 0;
            cur_step = step_base;
         end
         res.new_value = stepped_value(ev.current_value, ev.direction);
         res.accepted = 1'b1;
      end else begin
         release_hold();
      end
      res.overflow = limit_hit;
      res.repeat_interval = interval_now;
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) awaited_adjustments.push_back(next_adjustment(req_data));
         if (!req_valid || !req_stall) begin
            if (key_events_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data <= key_events_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_adjustments.size() == 0) begin
               fail_count++;
               $display("%0t: response transaction with none awaited, expected nothing, actual %h",
                        $time, rsp_data);
            end else begin
               oldest_adjustment = awaited_adjustments.pop_front();
               check_field("accepted", oldest_adjustment.accepted, rsp_data.accepted);
               check_field("new_value", oldest_adjustment.new_value, rsp_data.new_value);
               check_field("overflow", oldest_adjustment.overflow, rsp_data.overflow);
               check_field("repeat_interval", oldest_adjustment.repeat_interval,
                           rsp_data.repeat_interval);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic add_event(logic [1:0] kind, logic up, logic [15:0] value);
      req_type ev;
      ev.key_event = kind;
      ev.direction = up;
      ev.current_value = value;
      key_events_to_send.push_back(ev);
   endtask

   function automatic logic [15:0] pick_value();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'd0;
         1: v = 16'hFFFF;
         2: v = lo_limit[15:0];
         3: v = hi_limit[15:0];
         4: v = 16'(lo_limit + $urandom_range(0, 30));
         5: v = 16'(hi_limit - $urandom_range(0, 30));
         6: v = 16'($urandom_range(0, 6553) * 10);
         default: v = 16'($urandom_range(0, 65535));
      endcase
      return v;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
   endtask

   task automatic configure(int unsigned lo, int unsigned hi, int unsigned base,
                            int unsigned target, int unsigned accel);
      write_csr(CSR_MIN_VALUE, lo);
      write_csr(CSR_MAX_VALUE, hi);
      write_csr(CSR_BASE_STEP, base);
      write_csr(CSR_TARGET_STEP, target);
      write_csr(CSR_ACCEL_ENABLE, accel);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lo_limit = lo & 16'hFFFF;
      hi_limit = hi & 16'hFFFF;
      step_base = base & 8'hFF;
      step_target = target & 8'hFF;
      accel_on = accel & 1;
   endtask

   // checked at the falling edge so that the driver's update has settled
   task automatic drain();
      do @(negedge clock);
      while (key_events_to_send.size() != 0 || awaited_adjustments.size() != 0 || req_valid);
      repeat (3) @(posedge clock);
   endtask

   // mostly press-and-hold runs with a wandering value, the rest noise
   task automatic add_random_events(int count);
      int made;
      int ticks;
      logic up;
      logic [15:0] walk;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 9) < 7) begin
            up = 1'($urandom_range(0, 1));
            walk = pick_value();
            add_event(KEY_PRESS, up, walk);
            ticks = ($urandom_range(0, 9) < 4) ? $urandom_range(HOLD_LIMIT + 1, 60) :
                    $urandom_range(1, 12);
            for (int i = 0; i < ticks; i++) begin
               if ($urandom_range(0, 9) < 3) walk = walk - walk % 10;
               else if (up) walk = walk + 16'($urandom_range(0, 15));
               else walk = walk - 16'($urandom_range(0, 15));
               add_event(KEY_REPEAT, up, walk);
            end
            if ($urandom_range(0, 1) == 1)
               add_event(KEY_NONE, 1'($urandom_range(0, 1)), pick_value());
            made += ticks + 2;
         end else begin
            add_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_value());
            made++;
         end
      end
   endtask

   initial begin
      lo_limit = MIN_VALUE_RESET;
      hi_limit = MAX_VALUE_RESET;
      step_base = BASE_STEP_RESET;
      step_target = TARGET_STEP_RESET;
      accel_on = ACCEL_ENABLE_RESET;
      hold_ticks = 0;
      cur_step = BASE_STEP_RESET;
      seen_ten = 0;
      interval_now = '0;
      limit_hit = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: ;  // registers left at their reset values
            1: configure(0, 65535, 255, 255, 1);
            2: configure(100, 200, 7, 30, 1);
            3: configure(65535, 0, 1, 1, 0);
            4: configure(0, 65535, 1, 255, 1);
            5: configure(500, 500, 3, 12, 1);
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(1, 255), $urandom_range(1, 255),
                            $urandom_range(0, 1));
               end else begin
                  lo_limit = $urandom_range(0, 3000);
                  configure(lo_limit, lo_limit + $urandom_range(0, 5000),
                            $urandom_range(1, 5), $urandom_range(1, 40),
                            ($urandom_range(0, 3) != 0));
               end
            end
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         if (phase == 0) begin
            add_event(KEY_NONE, 1'b0, 16'd1234);
            add_event(KEY_RESERVED, 1'b1, 16'hFFFF);
            add_event(KEY_PRESS, 1'b1, 16'd0);
            add_event(KEY_PRESS, 1'b0, 16'd0);       // zero always counts as overflow
            add_event(KEY_PRESS, 1'b0, 16'd1);
            add_event(KEY_PRESS, 1'b1, 16'hFFFF);    // sum formed without wrap
            add_event(KEY_PRESS, 1'b0, 16'hFFFF);
            add_event(KEY_REPEAT, 1'b1, 16'd10);
            add_event(KEY_REPEAT, 1'b1, 16'd11);
            add_event(KEY_REPEAT, 1'b1, 16'd20);
            add_event(KEY_REPEAT, 1'b0, 16'd21);
            add_event(KEY_NONE, 1'b1, 16'd0);        // held flag shown on idle transaction
            add_event(KEY_REPEAT, 1'b0, 16'd0);
            add_event(KEY_RESERVED, 1'b0, 16'd77);
            add_event(KEY_PRESS, 1'b0, 16'h8000);
            add_event(KEY_PRESS, 1'b1, 16'h7FFF);
         end
         add_random_events(EVENTS_PER_PHASE);
         drain();
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/ava_pkg.sv
src/accelerated_value_adjuster.sv
dv/tb.sv
